// File: hdl/prmv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prmv_pkg
// shared widths, constants and carried-data types of the running mean and
// variance block
// ----------------------------------------------------------------------------
package prmv_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int M2_W       = 64;
  localparam int VAR_W      = 48;
  localparam int COUNT_W    = 32;
  localparam int FE_W       = 13;
  localparam int PROD_SHIFT = 16;

  localparam logic [FE_W-1:0] FE_RESET = 13'd1024;

  // one entry of the element state memory
  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [M2_W-1:0]     m2;
  } state_word_t;

  // data carried alongside the mean divider
  typedef struct packed {
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] mag_delta;
    logic                neg;
    logic [M2_W-1:0]     m2;
    logic [COUNT_W-1:0]  n_m1;
    logic                n_gt1;
    logic                last;
  } div1_side_t;

  // data carried alongside the variance divider
  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic                n_gt1;
    logic                last;
  } div2_side_t;

endpackage

// File: hdl/prmv_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prmv_div_pipe
// pipelined restoring divider, one quotient bit per stage, with side data
// ----------------------------------------------------------------------------
module prmv_div_pipe #(
  parameter int DW = 32,
  parameter int VW = 32,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_dividend,
  input  logic [VW-1:0] in_divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [DW-1:0] out_quotient,
  output logic [SW-1:0] out_side
);

  logic          valid_q [DW];
  logic [VW-1:0] rem_q   [DW];
  logic [DW-1:0] dq_q    [DW];
  logic [VW-1:0] div_q   [DW];
  logic [SW-1:0] side_q  [DW];

  for (genvar i = 0; i < DW; i++) begin : g_step
    logic          v_i;
    logic [VW-1:0] rem_i;
    logic [DW-1:0] dq_i;
    logic [VW-1:0] d_i;
    logic [SW-1:0] side_i;
    logic [VW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign dq_i   = in_dividend;
      assign d_i    = in_divisor;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = valid_q[i-1];
      assign rem_i  = rem_q[i-1];
      assign dq_i   = dq_q[i-1];
      assign d_i    = div_q[i-1];
      assign side_i = side_q[i-1];
    end

    // shift in the next dividend bit, subtract where it fits
    assign trial = {rem_i, dq_i[DW-1]};
    assign ge    = trial >= {1'b0, d_i};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i] <= 1'b0;
      end else if (en) begin
        valid_q[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= ge ? VW'(trial - {1'b0, d_i}) : trial[VW-1:0];
        dq_q[i]   <= {dq_i[DW-2:0], ge};
        div_q[i]  <= d_i;
        side_q[i] <= side_i;
      end
    end
  end

  assign out_valid    = valid_q[DW-1];
  assign out_quotient = dq_q[DW-1];
  assign out_side     = side_q[DW-1];

endmodule

// File: hdl/prmv_state_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prmv_state_mem
// element state memory with one read and one write port and a clearing
// pass after reset
// ----------------------------------------------------------------------------
module prmv_state_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output prmv_pkg::state_word_t     rd_data,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  prmv_pkg::state_word_t     wr_data,
  output logic                      busy
);
  import prmv_pkg::*;

  state_word_t       mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;
  logic              clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign busy = clearing;

endmodule

// File: hdl/per_element_running_mean_variance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_element_running_mean_variance
// per-element running mean and variance of streamed frames (welford update)
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with sample_value (signed q16.16) and
//   frame_last; one request is one grid element, raster order.
//   output channel: out_valid / out_stall with mean_value, variance_value
//   (unsigned q32.16, saturating), variance_valid and result_last; exactly
//   one result per accepted request, in order.
//   cfg_wr_en / cfg_wr_data write frame_elements, only while idle.
//   throughput: one request per cycle while in_stall is low. a request to
//   an element waits until the previous request to that element has written
//   back its state (read-modify-write window), so frames shorter than the
//   window run slower.
//   pipeline: read stage, 32-stage mean divider, product and accumulate
//   stages, 64-stage variance divider and the output register.
//   reset: synchronous rst; afterwards the state memory is cleared one
//   entry a cycle, all MAX_ELEMENTS entries, with in_stall high meanwhile.
//   a stalled output is parked in an output register plus a skid entry;
//   only when both are full does the pipeline freeze and raise in_stall.
// ----------------------------------------------------------------------------
module per_element_running_mean_variance #(
  parameter int MAX_ELEMENTS = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [prmv_pkg::FE_W-1:0]        cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [prmv_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                             frame_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [prmv_pkg::SAMPLE_W-1:0] mean_value,
  output logic [prmv_pkg::VAR_W-1:0]       variance_value,
  output logic                             variance_valid,
  output logic                             result_last
);
  import prmv_pkg::*;

  localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CMP_W  = (IDX_W + 1 > FE_W) ? IDX_W + 1 : FE_W;
  localparam int HZ_N   = SAMPLE_W + 3;   // stage a, divider stages, b, c
  localparam int SIDE1_W = $bits(div1_side_t) + IDX_W;
  localparam int SIDE2_W = $bits(div2_side_t);

  // configuration and frame tracking
  logic [FE_W-1:0]    frame_elements;
  logic [COUNT_W-1:0] frame_count;
  logic [COUNT_W-1:0] frame_count_next;
  logic [IDX_W-1:0]   element_position;
  logic [IDX_W-1:0]   element_position_next;
  logic [CMP_W-1:0]   limit;
  logic [CMP_W-1:0]   pos_inc;
  logic               ends;

  // pipeline control
  logic en;
  logic accept;
  logic busy;
  logic hazard;

  // hazard tracking: one entry per stage between read and write-back
  logic             hz_valid [HZ_N];
  logic [IDX_W-1:0] hz_pos   [HZ_N];

  // stage a: memory data arrives
  logic                a_valid;
  logic [SAMPLE_W-1:0] a_x;
  logic [IDX_W-1:0]    a_pos;
  logic [COUNT_W-1:0]  a_n;
  logic                a_last;
  state_word_t         rd_data;
  logic [SAMPLE_W:0]   a_delta;
  logic [SAMPLE_W-1:0] a_mag;
  div1_side_t          a_side;

  // mean divider
  logic                d1_valid;
  logic [SAMPLE_W-1:0] d1_quot;
  logic [SIDE1_W-1:0]  d1_side_vec;
  div1_side_t          d1_side;
  logic [IDX_W-1:0]    d1_pos;
  logic [SAMPLE_W+1:0] d1_step;
  logic [SAMPLE_W+1:0] d1_newmean;
  logic [SAMPLE_W+1:0] d1_delta2;
  logic [SAMPLE_W-1:0] d1_mag2;

  // stage b: operands of the product
  logic                b_valid;
  logic [SAMPLE_W-1:0] b_magd;
  logic [SAMPLE_W-1:0] b_magd2;
  logic [SAMPLE_W-1:0] b_mean;
  logic [M2_W-1:0]     b_m2;
  logic [COUNT_W-1:0]  b_nm1;
  logic                b_ngt1;
  logic                b_last;
  logic [IDX_W-1:0]    b_pos;

  // stage c: product registered, m2 accumulate and write-back
  logic                c_valid;
  logic [M2_W-1:0]     c_prod;
  logic [SAMPLE_W-1:0] c_mean;
  logic [M2_W-1:0]     c_m2;
  logic [COUNT_W-1:0]  c_nm1;
  logic                c_ngt1;
  logic                c_last;
  logic [IDX_W-1:0]    c_pos;
  logic [M2_W:0]       c_sum;
  logic [M2_W-1:0]     c_m2_new;
  state_word_t         wr_data;
  div2_side_t          c_side;

  // variance divider
  logic               d2_valid;
  logic [M2_W-1:0]    d2_quot;
  logic [SIDE2_W-1:0] d2_side_vec;
  div2_side_t         d2_side;
  logic [VAR_W-1:0]   d2_var;

  // skid entry
  logic                skid_valid;
  logic [SAMPLE_W-1:0] skid_mean;
  logic [VAR_W-1:0]    skid_var;
  logic                skid_vvalid;
  logic                skid_last;

  // pipeline moves unless the skid entry holds a result
  assign en       = !skid_valid;
  assign in_stall = !en || busy || hazard;
  assign accept   = in_valid && !in_stall;

  // frame limit, clamped to 1 .. MAX_ELEMENTS
  always_comb begin
    if (frame_elements == '0) begin
      limit = CMP_W'(1);
    end else if (CMP_W'(frame_elements) > CMP_W'(MAX_ELEMENTS)) begin
      limit = CMP_W'(MAX_ELEMENTS);
    end else begin
      limit = CMP_W'(frame_elements);
    end
  end

  assign pos_inc = CMP_W'(element_position) + 1'b1;
  assign ends    = frame_last || (pos_inc >= limit);
  assign element_position_next = ends ? '0 : pos_inc[IDX_W-1:0];

  // the count rises on the first element of each frame, saturating
  assign frame_count_next = (element_position == '0 && frame_count != '1) ?
                            frame_count + 1'b1 : frame_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_elements <= FE_RESET;
    end else if (cfg_wr_en) begin
      frame_elements <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count      <= '0;
      element_position <= '0;
    end else if (accept) begin
      frame_count      <= frame_count_next;
      element_position <= element_position_next;
    end
  end

  // read-after-write interlock on the element in flight
  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < HZ_N; i++) begin
      if (hz_valid[i] && hz_pos[i] == element_position) begin
        hazard = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HZ_N; i++) begin
        hz_valid[i] <= 1'b0;
      end
    end else if (en) begin
      hz_valid[0] <= accept;
      for (int i = 1; i < HZ_N; i++) begin
        hz_valid[i] <= hz_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hz_pos[0] <= element_position;
      for (int i = 1; i < HZ_N; i++) begin
        hz_pos[i] <= hz_pos[i-1];
      end
    end
  end

  prmv_state_mem #(
    .DEPTH  (MAX_ELEMENTS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (en),
    .rd_addr (element_position),
    .rd_data (rd_data),
    .wr_en   (c_valid && en),
    .wr_addr (c_pos),
    .wr_data (wr_data),
    .busy    (busy)
  );

  // stage a register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x    <= sample_value;
      a_pos  <= element_position;
      a_n    <= frame_count_next;
      a_last <= ends;
    end
  end

  // delta = x - mean, magnitude fits 32 bits
  assign a_delta = {a_x[SAMPLE_W-1], a_x} - {rd_data.mean[SAMPLE_W-1], rd_data.mean};
  assign a_mag   = a_delta[SAMPLE_W] ? SAMPLE_W'(-a_delta) : a_delta[SAMPLE_W-1:0];

  always_comb begin
    a_side.x         = a_x;
    a_side.mean      = rd_data.mean;
    a_side.mag_delta = a_mag;
    a_side.neg       = a_delta[SAMPLE_W];
    a_side.m2        = rd_data.m2;
    a_side.n_m1      = a_n - 1'b1;
    a_side.n_gt1     = a_n > COUNT_W'(1);
    a_side.last      = a_last;
  end

  // |delta| / n, truncated
  prmv_div_pipe #(
    .DW (SAMPLE_W),
    .VW (COUNT_W),
    .SW (SIDE1_W)
  ) u_div_mean (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (a_valid),
    .in_dividend  (a_mag),
    .in_divisor   (a_n),
    .in_side      ({a_side, a_pos}),
    .out_valid    (d1_valid),
    .out_quotient (d1_quot),
    .out_side     (d1_side_vec)
  );

  assign d1_side = d1_side_vec[SIDE1_W-1:IDX_W];
  assign d1_pos  = d1_side_vec[IDX_W-1:0];

  // new mean and second difference, which shares the sign of delta
  assign d1_step    = d1_side.neg ? -{2'b00, d1_quot} : {2'b00, d1_quot};
  assign d1_newmean = {{2{d1_side.mean[SAMPLE_W-1]}}, d1_side.mean} + d1_step;
  assign d1_delta2  = {{2{d1_side.x[SAMPLE_W-1]}}, d1_side.x} - d1_newmean;
  assign d1_mag2    = d1_delta2[SAMPLE_W+1] ? SAMPLE_W'(-d1_delta2) :
                      d1_delta2[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (en) begin
      b_valid <= d1_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_magd  <= d1_side.mag_delta;
      b_magd2 <= d1_mag2;
      b_mean  <= d1_newmean[SAMPLE_W-1:0];
      b_m2    <= d1_side.m2;
      b_nm1   <= d1_side.n_m1;
      b_ngt1  <= d1_side.n_gt1;
      b_last  <= d1_side.last;
      b_pos   <= d1_pos;

      c_prod  <= b_magd * b_magd2;
      c_mean  <= b_mean;
      c_m2    <= b_m2;
      c_nm1   <= b_nm1;
      c_ngt1  <= b_ngt1;
      c_last  <= b_last;
      c_pos   <= b_pos;
    end
  end

  // m2 accumulate, saturating at all ones
  assign c_sum    = {1'b0, c_m2} + (M2_W + 1)'(c_prod[M2_W-1:PROD_SHIFT]);
  assign c_m2_new = c_sum[M2_W] ? '1 : c_sum[M2_W-1:0];

  assign wr_data.mean = c_mean;
  assign wr_data.m2   = c_m2_new;

  assign c_side.mean  = c_mean;
  assign c_side.n_gt1 = c_ngt1;
  assign c_side.last  = c_last;

  // m2 / (n - 1)
  prmv_div_pipe #(
    .DW (M2_W),
    .VW (COUNT_W),
    .SW (SIDE2_W)
  ) u_div_var (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (c_valid),
    .in_dividend  (c_m2_new),
    .in_divisor   (c_nm1),
    .in_side      (c_side),
    .out_valid    (d2_valid),
    .out_quotient (d2_quot),
    .out_side     (d2_side_vec)
  );

  assign d2_side = d2_side_vec;

  // first frame reads as zero, otherwise saturate to 48 bits
  always_comb begin
    if (!d2_side.n_gt1) begin
      d2_var = '0;
    end else if (|d2_quot[M2_W-1:VAR_W]) begin
      d2_var = '1;
    end else begin
      d2_var = d2_quot[VAR_W-1:0];
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        mean_value     <= skid_mean;
        variance_value <= skid_var;
        variance_valid <= skid_vvalid;
        result_last    <= skid_last;
        skid_valid     <= 1'b0;
      end
    end else if (d2_valid) begin
      if (!out_valid || !out_stall) begin
        mean_value     <= d2_side.mean;
        variance_value <= d2_var;
        variance_valid <= d2_side.n_gt1;
        result_last    <= d2_side.last;
        out_valid      <= 1'b1;
      end else begin
        skid_mean   <= d2_side.mean;
        skid_var    <= d2_var;
        skid_vvalid <= d2_side.n_gt1;
        skid_last   <= d2_side.last;
        skid_valid  <= 1'b1;
      end
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: tb/tb_per_element_running_mean_variance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_element_running_mean_variance
// self-checking bench for the per-element running mean and variance block:
// a local welford predictor works out the mean, variance and frame flags of
// each accepted request, and a checker compares each result in order, with
// random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module tb_per_element_running_mean_variance;
  import prmv_pkg::*;

  localparam int MAX_EL      = 4096;
  localparam int DRAIN_WAIT  = 130;    // a little over the pipeline latency
  localparam int STUCK_LIMIT = 30000;  // covers the clearing pass after reset
  localparam int RANDOM_REQS = 1300;
  localparam logic [VAR_W-1:0] VAR_SAT = {VAR_W{1'b1}};

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [VAR_W-1:0]    variance;
    logic                var_ok;
    logic                last;
  } stats_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [FE_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic frame_last;
  logic out_valid;
  logic out_stall;
  logic signed [SAMPLE_W-1:0] mean_value;
  logic [VAR_W-1:0] variance_value;
  logic variance_valid;
  logic result_last;

  // predictor state: register copy, frame counter, position and per-element stores
  logic [FE_W-1:0]     fe_copy;
  logic [COUNT_W-1:0]  frames_seen;
  int unsigned         elem_pos;
  logic [SAMPLE_W-1:0] mean_mem [MAX_EL];
  logic [M2_W-1:0]     sq_dev_mem [MAX_EL];

  stats_t expected_stats [$];
  int     mismatches;
  bit     send_burst;   // no gaps on the request side
  bit     drain_burst;  // no stalls on the result side
  int     stall_left;
  int     idle_cycles;

  per_element_running_mean_variance dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample_value  (sample_value),
    .frame_last    (frame_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .mean_value    (mean_value),
    .variance_value(variance_value),
    .variance_valid(variance_valid),
    .result_last   (result_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // welford update for one accepted request, mirrors the block bit for bit
  function automatic void predict_welford(input logic [SAMPLE_W-1:0] s, input logic l);
    int unsigned lim;
    int unsigned p;
    logic [63:0] n;
    longint x, m, d, stp, nm, d2;
    logic [63:0] mag_d, mag_d2, q, prod, m2, vr;
    bit ends;
    stats_t r;
    lim = fe_copy;
    if (lim < 1) lim = 1;
    if (lim > MAX_EL) lim = MAX_EL;
    p = elem_pos;
    if (p >= MAX_EL) p = 0;
    // the frame count rises on position zero and sticks at its top
    if (p == 0 && frames_seen != {COUNT_W{1'b1}}) frames_seen = frames_seen + 1;
    n = (frames_seen == 0) ? 64'd1 : {32'd0, frames_seen};
    x = longint'($signed(s));
    m = longint'($signed(mean_mem[p]));
    d = x - m;
    mag_d = (d < 0) ? 64'(-d) : 64'(d);
    q = mag_d / n;
    stp = (d < 0) ? -longint'(q) : longint'(q);
    nm = m + stp;
    d2 = x - nm;
    mag_d2 = (d2 < 0) ? 64'(-d2) : 64'(d2);
    prod = (mag_d * mag_d2) >> PROD_SHIFT;
    m2 = sq_dev_mem[p];
    if (m2 > ~64'd0 - prod) m2 = ~64'd0;
    else m2 = m2 + prod;
    mean_mem[p] = nm[SAMPLE_W-1:0];
    sq_dev_mem[p] = m2;
    if (n <= 1) begin
      vr = 0;
    end else begin
      vr = m2 / (n - 1);
      if (vr > {16'd0, VAR_SAT}) vr = {16'd0, VAR_SAT};
    end
    ends = l || (p + 1 >= lim);
    elem_pos = ends ? 0 : ((p + 1) & 12'hFFF);
    r.mean = nm[SAMPLE_W-1:0];
    r.variance = vr[VAR_W-1:0];
    r.var_ok = (n > 1);
    r.last = ends;
    expected_stats.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 60)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // result side: check each accepted result and draw the next stall
  always @(posedge clk) begin
    stats_t w;
    int gap;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        report_mismatch("unexpected result", {32'd0, mean_value}, 64'd0);
      end else begin
        w = expected_stats.pop_front();
        if (mean_value !== w.mean) report_mismatch("mean", 64'(mean_value), 64'(w.mean));
        if (variance_value !== w.variance)
          report_mismatch("variance", 64'(variance_value), 64'(w.variance));
        if (variance_valid !== w.var_ok)
          report_mismatch("variance_valid", 64'(variance_valid), 64'(w.var_ok));
        if (result_last !== w.last)
          report_mismatch("result_last", 64'(result_last), 64'(w.last));
      end
      gap = drain_burst ? 0 : $urandom_range(0, 9);
      stall_left <= gap;
      out_stall <= (gap != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  // watchdog: too long with nothing moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // one request; called just after a rising edge, returns at the accepting edge
  task automatic send_request(input logic [SAMPLE_W-1:0] s, input logic l);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_value <= s;
    frame_last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_welford(s, l);
  endtask

  // idle means nothing owed and the pipeline empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_frame_elements(input logic [FE_W-1:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    fe_copy = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // a sample near a base value, or now and then anything at all
  function automatic logic [SAMPLE_W-1:0] draw_sample(input logic [SAMPLE_W-1:0] base);
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return base + ($urandom_range(0, 32'h3_FFFF) - 32'h2_0000);
    endcase
  endfunction

  // first frame under the reset register value, variance not yet valid
  task automatic test_first_frame();
    send_request(32'h7FFF_FFFF, 1'b0);
    send_request(32'h8000_0000, 1'b0);
    send_request(32'h0000_0000, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b0);
    send_request(32'h0001_0000, 1'b1);
  endtask

  // extremes flipping between frames drive delta and m2 to their largest
  task automatic test_extremes();
    send_request(32'h8000_0000, 1'b0);
    send_request(32'h7FFF_FFFF, 1'b0);
    send_request(32'h7FFF_FFFF, 1'b0);
    send_request(32'h8000_0000, 1'b0);
    send_request(32'h5555_5555, 1'b1);
    send_request(32'h7FFF_FFFF, 1'b0);
    send_request(32'h8000_0000, 1'b0);
    send_request(32'h8000_0000, 1'b0);
    send_request(32'h7FFF_FFFF, 1'b0);
    send_request(32'hAAAA_AAAA, 1'b1);
    // frame_last on position zero: a one-element frame
    send_request(32'h7FFF_FFFF, 1'b1);
  endtask

  // zero acts as one, above the store size acts as the store size
  task automatic test_register_extremes();
    int i;
    write_frame_elements(13'd0);
    for (i = 0; i < 4; i++) send_request($urandom(), 1'b0);
    write_frame_elements(13'd1);
    for (i = 0; i < 3; i++) send_request($urandom(), 1'b0);
    write_frame_elements(13'h1FFF);
    for (i = 0; i < 8; i++) send_request($urandom(), i == 7);
    // a frame ended by the position limit alone
    write_frame_elements(13'd5);
    send_burst = 1'b1;
    for (i = 0; i < 5; i++) send_request($urandom(), 1'b0);
    send_burst = 1'b0;
  endtask

  // register shrunk below the current position mid-frame
  task automatic test_shrink_mid_frame();
    int i;
    write_frame_elements(13'd20);
    for (i = 0; i < 6; i++) send_request($urandom(), 1'b0);
    write_frame_elements(13'd3);
    for (i = 0; i < 5; i++) send_request($urandom(), 1'b0);
  endtask

  // well-formed frames with random content, some cut short
  task automatic test_random_frames();
    int sent;
    int len;
    int i;
    int phase;
    logic [SAMPLE_W-1:0] base [48];
    sent = 0;
    phase = 0;
    while (sent < RANDOM_REQS) begin
      len = (phase % 5 == 4) ? $urandom_range(1, 3) : $urandom_range(4, 48);
      write_frame_elements(FE_W'(len));
      for (i = 0; i < 48; i++) base[i] = $urandom();
      repeat ($urandom_range(3, 10)) begin
        send_burst = ($urandom_range(0, 3) == 0);
        drain_burst = ($urandom_range(0, 3) == 0);
        for (i = 0; i < len; i++) begin
          // mostly end on the limit, sometimes with frame_last, rarely early
          if ($urandom_range(0, 19) == 0 && i < len - 1) begin
            send_request(draw_sample(base[i]), 1'b1);
            sent++;
            break;
          end
          send_request(draw_sample(base[i]), (i == len - 1) && $urandom_range(0, 1));
          sent++;
        end
      end
      send_burst = 1'b0;
      drain_burst = 1'b0;
      phase++;
    end
    write_frame_elements(13'd4096);
  endtask

  initial begin
    mismatches = 0;
    send_burst = 1'b0;
    drain_burst = 1'b0;
    fe_copy = FE_RESET;
    frames_seen = 0;
    elem_pos = 0;
    for (int i = 0; i < MAX_EL; i++) begin
      mean_mem[i] = 0;
      sq_dev_mem[i] = 0;
    end
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    sample_value <= '0;
    frame_last <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_frame();
    test_extremes();
    test_shrink_mid_frame();
    test_register_extremes();
    test_random_frames();
    wait_drained();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/prmv_pkg.sv
hdl/prmv_div_pipe.sv
hdl/prmv_state_mem.sv
hdl/per_element_running_mean_variance.sv
tb/tb_per_element_running_mean_variance.sv
